>>> design/cfm_pkg.sv
// Shared constants, types and helper functions of the binary context frequency model.
package cfm_pkg;

    // Field widths of the channels.
    localparam int RATIO_W     = 4;
    localparam int LAST_BITS_W = 8;
    localparam int TREND_W     = 2;
    localparam int DEPTH_W     = 8;
    localparam int MAXVAL_W    = 8;
    localparam int FREQ_W      = 9;
    localparam int TOTAL_W     = 10;
    localparam int THRESH_W    = 9;

    // Context field sizes inside the table index.
    localparam int RATIO_BITS   = 4;
    localparam int HISTORY_BITS = 2;
    localparam int TREND_BITS   = 2;
    localparam int DEPTH_BITS   = 3;
    localparam int MAXVAL_BITS  = 2;

    // Tables are stored as pairs of entries, one pair per memory word.
    localparam int PRI_PAIR_BITS = RATIO_BITS + HISTORY_BITS + TREND_BITS + DEPTH_BITS
                                   + MAXVAL_BITS;
    localparam int SEC_PAIR_BITS = RATIO_BITS + HISTORY_BITS;
    localparam int PRI_PAIRS     = 1 << PRI_PAIR_BITS;
    localparam int SEC_PAIRS     = 1 << SEC_PAIR_BITS;
    localparam int ENTRY_W       = 8;

    localparam int BLEND_LIMIT  = 16;
    localparam int HALVE_LIMIT  = 250;
    localparam int PRI_GAIN     = 4;
    localparam int MAXVAL_CLAMP = 3;
    localparam int THRESH_RESET = 8;

    typedef enum logic {
        CMD_PREDICT = 1'b0,
        CMD_UPDATE  = 1'b1
    } t_cmd;

    typedef logic [ENTRY_W-1:0]       t_entry;
    typedef t_entry [1:0]             t_pair;
    typedef logic [PRI_PAIR_BITS-1:0] t_pri_addr;
    typedef logic [SEC_PAIR_BITS-1:0] t_sec_addr;

    // Requests from the control logic to the table memories.
    typedef struct packed {
        logic      rd_en;
        t_pri_addr pri_rd_a;
        t_pri_addr pri_rd_b;
        t_sec_addr sec_rd;
        logic      pri_we;
        t_pri_addr pri_wa;
        t_pair     pri_wd;
        logic      sec_we;
        t_sec_addr sec_wa;
        t_pair     sec_wd;
    } t_mem_req;

    // Registered read data of the table memories.
    typedef struct packed {
        t_pair pri_a;
        t_pair pri_b;
        t_pair sec;
    } t_mem_rsp;

    typedef struct packed {
        logic [FREQ_W-1:0]  freq_zero;
        logic [FREQ_W-1:0]  freq_one;
        logic [TOTAL_W-1:0] freq_total;
        logic               from_secondary;
    } t_result;

    localparam logic [MAXVAL_BITS-1:0] MAXV_TOP = MAXVAL_BITS'(MAXVAL_CLAMP);

    function automatic logic [MAXVAL_BITS-1:0] clamp_maxv(input logic [MAXVAL_W-1:0] v);
        logic [MAXVAL_BITS-1:0] r;
        if (v > MAXVAL_W'(MAXVAL_CLAMP)) begin
            r = MAXV_TOP;
        end else begin
            r = v[MAXVAL_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_pri_addr pri_pair_of(
        input logic [RATIO_W-1:0]     ratio,
        input logic [LAST_BITS_W-1:0] last_bits,
        input logic [TREND_W-1:0]     trend,
        input logic [DEPTH_W-1:0]     depth,
        input logic [MAXVAL_W-1:0]    max_value
    );
        logic [DEPTH_BITS-1:0] d;
        if (depth > DEPTH_W'((1 << DEPTH_BITS) - 1)) begin
            d = '1;
        end else begin
            d = depth[DEPTH_BITS-1:0];
        end
        return {ratio[RATIO_BITS-1:0], last_bits[HISTORY_BITS-1:0],
                trend[TREND_BITS-1:0], d, clamp_maxv(max_value)};
    endfunction

    function automatic t_sec_addr sec_pair_of(input logic [RATIO_W-1:0] ratio);
        return {ratio[RATIO_BITS-1:0], {HISTORY_BITS{1'b0}}};
    endfunction

endpackage

>>> design/cfm_item_if.sv
// Input item channel: command with context fields or coded bit.
interface cfm_item_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [cfm_pkg::RATIO_W-1:0]       ratio;
    logic [cfm_pkg::LAST_BITS_W-1:0]   last_bits;
    logic [cfm_pkg::TREND_W-1:0]       trend;
    logic [cfm_pkg::DEPTH_W-1:0]       depth;
    logic [cfm_pkg::MAXVAL_W-1:0]      max_value;
    logic                              coded_bit;

    modport source (output valid, cmd, ratio, last_bits, trend, depth, max_value, coded_bit,
                    input ready);
    modport sink (input valid, cmd, ratio, last_bits, trend, depth, max_value, coded_bit,
                  output ready);
endinterface

>>> design/cfm_result_if.sv
// Result channel: predicted frequencies and their total.
interface cfm_result_if;
    logic                           valid;
    logic                           ready;
    logic [cfm_pkg::FREQ_W-1:0]     freq_zero;
    logic [cfm_pkg::FREQ_W-1:0]     freq_one;
    logic [cfm_pkg::TOTAL_W-1:0]    freq_total;
    logic                           from_secondary;

    modport source (output valid, freq_zero, freq_one, freq_total, from_secondary,
                    input ready);
    modport sink (input valid, freq_zero, freq_one, freq_total, from_secondary,
                  output ready);
endinterface

>>> design/cfm_cfg_if.sv
// Configuration write channel for the secondary threshold register.
interface cfm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cfm_pkg::THRESH_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> design/cfm_tables.sv
// Primary and secondary pair memories with the clearing sweep after reset.
module cfm_tables (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfm_pkg::t_mem_req i_req,
    output cfm_pkg::t_mem_rsp o_rsp,
    output logic              o_clearing
);
    import cfm_pkg::*;

    localparam t_pair PAIR_INIT = {ENTRY_W'(1), ENTRY_W'(1)};

    t_pair     pri_mem [PRI_PAIRS];
    t_pair     sec_mem [SEC_PAIRS];
    logic      r_clearing;
    t_pri_addr r_clr_addr;
    t_pair     r_pri_a;
    t_pair     r_pri_b;
    t_pair     r_sec;

    // The sweep restores every pair to the reset value, one primary word per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            pri_mem[r_clr_addr] <= PAIR_INIT;
        end else if (i_req.pri_we) begin
            pri_mem[i_req.pri_wa] <= i_req.pri_wd;
        end
        if (i_req.rd_en) begin
            r_pri_a <= pri_mem[i_req.pri_rd_a];
            r_pri_b <= pri_mem[i_req.pri_rd_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            sec_mem[r_clr_addr[SEC_PAIR_BITS-1:0]] <= PAIR_INIT;
        end else if (i_req.sec_we) begin
            sec_mem[i_req.sec_wa] <= i_req.sec_wd;
        end
        if (i_req.rd_en) begin
            r_sec <= sec_mem[i_req.sec_rd];
        end
    end

    assign o_rsp.pri_a = r_pri_a;
    assign o_rsp.pri_b = r_pri_b;
    assign o_rsp.sec   = r_sec;
    assign o_clearing  = r_clearing;

endmodule

>>> design/cfm_calc.sv
// Prediction blend and update training arithmetic on the pairs read from the tables.
module cfm_calc (
    input  cfm_pkg::t_mem_rsp            i_rsp,
    input  logic                         i_coded_bit,
    input  logic [cfm_pkg::THRESH_W-1:0] i_threshold,
    input  logic                         i_blend_ok,
    output cfm_pkg::t_result             o_result,
    output cfm_pkg::t_pair               o_pri_wd,
    output cfm_pkg::t_pair               o_sec_wd,
    output logic                         o_sec_train
);
    import cfm_pkg::*;

    function automatic t_entry halve(input t_entry x);
        return (x > ENTRY_W'(1)) ? (x >> 1) : x;
    endfunction

    logic [ENTRY_W:0] pri_tot;
    logic [ENTRY_W:0] gained;
    t_entry           sec_old;
    t_pair            pri_new;
    t_pair            sec_new;
    logic             use_sec;

    assign pri_tot = {1'b0, i_rsp.pri_a[0]} + {1'b0, i_rsp.pri_a[1]};
    assign use_sec = pri_tot < i_threshold;

    // Prediction: secondary if weak primary, else primary + neighbor if low and allowed.
    always_comb begin
        o_result = '0;
        if (use_sec) begin
            o_result.freq_zero      = FREQ_W'(i_rsp.sec[0]);
            o_result.freq_one       = FREQ_W'(i_rsp.sec[1]);
            o_result.freq_total     = TOTAL_W'(i_rsp.sec[0]) + TOTAL_W'(i_rsp.sec[1]);
            o_result.from_secondary = 1'b1;
        end else if (pri_tot < (ENTRY_W + 1)'(BLEND_LIMIT) && i_blend_ok) begin
            o_result.freq_zero  = FREQ_W'(i_rsp.pri_a[0]) + FREQ_W'(i_rsp.pri_b[0]);
            o_result.freq_one   = FREQ_W'(i_rsp.pri_a[1]) + FREQ_W'(i_rsp.pri_b[1]);
            o_result.freq_total = TOTAL_W'(pri_tot) + TOTAL_W'(i_rsp.pri_b[0])
                                  + TOTAL_W'(i_rsp.pri_b[1]);
        end else begin
            o_result.freq_zero  = FREQ_W'(i_rsp.pri_a[0]);
            o_result.freq_one   = FREQ_W'(i_rsp.pri_a[1]);
            o_result.freq_total = TOTAL_W'(pri_tot);
        end
    end

    // Update: gain on the coded entry, halving the pair once it passes the limit.
    assign gained = {1'b0, i_rsp.pri_a[i_coded_bit]} + (ENTRY_W + 1)'(PRI_GAIN);
    assign sec_old = i_rsp.sec[i_coded_bit];

    always_comb begin
        pri_new = i_rsp.pri_a;
        pri_new[i_coded_bit] = gained[ENTRY_W] ? '1 : gained[ENTRY_W-1:0];
        if (gained > (ENTRY_W + 1)'(HALVE_LIMIT)) begin
            pri_new[0] = halve(pri_new[0]);
            pri_new[1] = halve(pri_new[1]);
        end

        sec_new = i_rsp.sec;
        sec_new[i_coded_bit] = (sec_old == '1) ? sec_old : sec_old + 1'b1;
        if (sec_old > ENTRY_W'(HALVE_LIMIT)) begin
            sec_new[0] = halve(sec_new[0]);
            sec_new[1] = halve(sec_new[1]);
        end
    end

    assign o_pri_wd    = pri_new;
    assign o_sec_wd    = sec_new;
    assign o_sec_train = use_sec;

endmodule

>>> design/binary_context_frequency_model.sv
// Top level of the binary context frequency model: control, held indices and result register.
// Each transaction is accepted in the idle state, which issues the table reads, and finished
// in the execute state, which writes back (update) or loads the result register (predict)
// from the registered read data of the pair memories; a predict waits there until the result
// register is free. After reset the tables are swept to one, during which no item is accepted;
// configuration writes are taken at any time. Reset threshold is 8, held indices zero.
module binary_context_frequency_model (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cfm_item_if.sink     i_item,
    cfm_result_if.source o_result,
    cfm_cfg_if.sink      i_cfg
);
    import cfm_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic                 r_bit;
    t_pri_addr            r_pri_pair;
    t_sec_addr            r_sec_pair;
    logic [THRESH_W-1:0]  r_threshold;
    logic                 r_out_valid;
    t_result              r_out;

    t_mem_req   mem_req;
    t_mem_rsp   mem_rsp;
    logic       clearing;
    logic       accept;
    t_cmd       in_cmd;
    t_pri_addr  new_pri_pair;
    t_sec_addr  new_sec_pair;
    t_result    calc_result;
    t_pair      pri_wd;
    t_pair      sec_wd;
    logic       sec_train;
    logic       out_free;
    logic       exec_done;

    // Items are accepted only in the idle state, so a write-back always lands before the
    // next transaction reads the tables; no forwarding is needed.
    assign i_item.ready = (r_state == ST_IDLE) && !clearing;
    assign accept       = i_item.valid && i_item.ready;
    assign in_cmd       = t_cmd'(i_item.cmd);
    assign i_cfg.ready  = 1'b1;

    assign new_pri_pair = pri_pair_of(i_item.ratio, i_item.last_bits, i_item.trend,
                                      i_item.depth, i_item.max_value);
    assign new_sec_pair = sec_pair_of(i_item.ratio);

    // The result register can take a new prediction when empty or while being drained.
    assign out_free  = !r_out_valid || o_result.ready;
    assign exec_done = (r_state == ST_EXEC) && ((r_cmd == CMD_UPDATE) || out_free);

    always_comb begin
        mem_req          = '0;
        mem_req.rd_en    = accept;
        // An update works on the pairs latched by the last prediction.
        mem_req.pri_rd_a = (in_cmd == CMD_UPDATE) ? r_pri_pair : new_pri_pair;
        mem_req.pri_rd_b = new_pri_pair + 1'b1;
        mem_req.sec_rd   = (in_cmd == CMD_UPDATE) ? r_sec_pair : new_sec_pair;
        mem_req.pri_we   = (r_state == ST_EXEC) && (r_cmd == CMD_UPDATE);
        mem_req.pri_wa   = r_pri_pair;
        mem_req.pri_wd   = pri_wd;
        mem_req.sec_we   = mem_req.pri_we && sec_train;
        mem_req.sec_wa   = r_sec_pair;
        mem_req.sec_wd   = sec_wd;
    end

    cfm_tables u_tables (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rsp      (mem_rsp),
        .o_clearing (clearing)
    );

    // The neighbor blend applies only below the top max-value class.
    cfm_calc u_calc (
        .i_rsp       (mem_rsp),
        .i_coded_bit (r_bit),
        .i_threshold (r_threshold),
        .i_blend_ok  (r_pri_pair[MAXVAL_BITS-1:0] != MAXV_TOP),
        .o_result    (calc_result),
        .o_pri_wd    (pri_wd),
        .o_sec_wd    (sec_wd),
        .o_sec_train (sec_train)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmd       <= CMD_PREDICT;
            r_bit       <= 1'b0;
            r_pri_pair  <= '0;
            r_sec_pair  <= '0;
            r_threshold <= THRESH_W'(THRESH_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_threshold <= i_cfg.data;
            end
            // A drained result clears the valid flag unless a new prediction refills it.
            if (o_result.ready && !(exec_done && (r_cmd == CMD_PREDICT))) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd   <= in_cmd;
                        r_bit   <= i_item.coded_bit;
                        r_state <= ST_EXEC;
                        // Every prediction latches both pair indices.
                        if (in_cmd == CMD_PREDICT) begin
                            r_pri_pair <= new_pri_pair;
                            r_sec_pair <= new_sec_pair;
                        end
                    end
                end
                ST_EXEC: begin
                    if (exec_done) begin
                        r_state <= ST_IDLE;
                        if (r_cmd == CMD_PREDICT) begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_done && (r_cmd == CMD_PREDICT)) begin
            r_out <= calc_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.freq_zero      = r_out.freq_zero;
    assign o_result.freq_one       = r_out.freq_one;
    assign o_result.freq_total     = r_out.freq_total;
    assign o_result.from_secondary = r_out.from_secondary;

endmodule

>>> tb/binary_context_frequency_model_tb.sv
// Self-checking testbench of the binary context frequency model with its own table predictor.
module binary_context_frequency_model_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfm_pkg::*;

    // The limit must outlast the post-reset table sweep, in which no transaction completes.
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int THRESH_HIGH    = 510;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PRINT_LIMIT    = 100;

    // One input transaction as the stimulus sees it.
    typedef struct {
        t_cmd                   cmd;
        logic [RATIO_W-1:0]     ratio;
        logic [LAST_BITS_W-1:0] last_bits;
        logic [TREND_W-1:0]     trend;
        logic [DEPTH_W-1:0]     depth;
        logic [MAXVAL_W-1:0]    max_value;
        logic                   coded_bit;
    } t_coder_item;

    // Behaviors of the result receiver; it moves between them at random.
    typedef enum {
        RX_STEADY,
        RX_HALF,
        RX_SPARSE,
        RX_EAGER,
        RX_FROZEN
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    cfm_item_if   item_bus ();
    cfm_result_if result_bus ();
    cfm_cfg_if    cfg_bus ();

    binary_context_frequency_model DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    // Predictor state: both tables stored as pairs, the latched pair indices and the
    // threshold register as the block should hold them.
    logic [ENTRY_W-1:0]  pri_model [PRI_PAIRS][2];
    logic [ENTRY_W-1:0]  sec_model [SEC_PAIRS][2];
    t_pri_addr           held_pri_pair;
    t_sec_addr           held_sec_pair;
    logic [THRESH_W-1:0] thresh_model;

    t_coder_item pending_items [$];
    t_result     freq_expected [$];

    // Handshake flags, written at the rising edge and read at the falling edge.
    logic item_taken   = 1'b0;
    logic result_taken = 1'b0;
    logic cfg_taken    = 1'b0;

    int queued_items   = 0;
    int accepted_items = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Sender burst shaping and receiver stall pattern.
    int       burst_left    = 0;
    int       gap_left      = 0;
    t_rx_mode rx_mode       = RX_STEADY;
    int       rx_mode_left  = 0;
    int       hold_left     = 0;
    logic     hold_off_req  = 1'b0;
    logic     hold_off_done = 1'b0;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every input of the block gets a known value at time zero, and the predictor starts
    // from the reset state of the block.
    initial begin : reset_gen
        i_rst_n              = 1'b0;
        item_bus.valid       = 1'b0;
        item_bus.cmd         = CMD_PREDICT;
        item_bus.ratio       = '0;
        item_bus.last_bits   = '0;
        item_bus.trend       = '0;
        item_bus.depth       = '0;
        item_bus.max_value   = '0;
        item_bus.coded_bit   = 1'b0;
        result_bus.ready     = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.data         = '0;
        for (int p = 0; p < PRI_PAIRS; p++) begin
            pri_model[p][0] = 8'd1;
            pri_model[p][1] = 8'd1;
        end
        for (int p = 0; p < SEC_PAIRS; p++) begin
            sec_model[p][0] = 8'd1;
            sec_model[p][1] = 8'd1;
        end
        held_pri_pair = '0;
        held_sec_pair = '0;
        thresh_model  = THRESH_W'(THRESH_RESET);
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // A predict packs the context into a primary pair index and latches it with the
    // secondary pair of its ratio. A small primary total hands the answer to the secondary
    // table; under the blend limit, the next max-value pair is added while below the clamp.
    function automatic t_result predict_frequencies(input t_coder_item it);
        int        depth_sat;
        int        maxv;
        int        pair_idx;
        int        zero_f;
        int        one_f;
        int        total_f;
        t_pri_addr next_pair;
        t_result   r;
        depth_sat = (1 << DEPTH_BITS) - 1;
        if (it.depth < depth_sat) begin
            depth_sat = it.depth;
        end
        maxv = (it.max_value > MAXVAL_CLAMP) ? MAXVAL_CLAMP : it.max_value;
        pair_idx = it.ratio & ((1 << RATIO_BITS) - 1);
        pair_idx = (pair_idx << HISTORY_BITS) | (it.last_bits & ((1 << HISTORY_BITS) - 1));
        pair_idx = (pair_idx << TREND_BITS) | (it.trend & ((1 << TREND_BITS) - 1));
        pair_idx = (pair_idx << DEPTH_BITS) | depth_sat;
        pair_idx = (pair_idx << MAXVAL_BITS) | maxv;
        held_pri_pair = t_pri_addr'(pair_idx);
        held_sec_pair = t_sec_addr'((it.ratio & ((1 << RATIO_BITS) - 1)) << HISTORY_BITS);

        zero_f  = pri_model[held_pri_pair][0];
        one_f   = pri_model[held_pri_pair][1];
        total_f = zero_f + one_f;
        r.from_secondary = 1'b0;
        if (total_f < int'(thresh_model)) begin
            zero_f  = sec_model[held_sec_pair][0];
            one_f   = sec_model[held_sec_pair][1];
            total_f = zero_f + one_f;
            r.from_secondary = 1'b1;
        end else if (total_f < BLEND_LIMIT && maxv < MAXVAL_CLAMP) begin
            next_pair = held_pri_pair + 1'b1;
            zero_f  += pri_model[next_pair][0];
            one_f   += pri_model[next_pair][1];
            total_f = zero_f + one_f;
        end
        r.freq_zero  = FREQ_W'(zero_f);
        r.freq_one   = FREQ_W'(one_f);
        r.freq_total = TOTAL_W'(total_f);
        return r;
    endfunction

    // An update grows the coded entry of the latched primary pair, and of the latched
    // secondary pair when the primary total was below the threshold at this moment. A pair
    // halves when its grown primary or old secondary entry passes the halving limit.
    function automatic void train_pairs(input logic coded);
        int pair_total;
        int grown;
        int old;
        pair_total = pri_model[held_pri_pair][0] + pri_model[held_pri_pair][1];
        grown = pri_model[held_pri_pair][coded] + PRI_GAIN;
        pri_model[held_pri_pair][coded] = (grown > 255) ? 8'd255 : ENTRY_W'(grown);
        if (grown > HALVE_LIMIT) begin
            for (int k = 0; k < 2; k++) begin
                if (pri_model[held_pri_pair][k] > 1) begin
                    pri_model[held_pri_pair][k] = pri_model[held_pri_pair][k] >> 1;
                end
            end
        end
        if (pair_total < int'(thresh_model)) begin
            old = sec_model[held_sec_pair][coded];
            sec_model[held_sec_pair][coded] = (old >= 255) ? 8'd255 : ENTRY_W'(old + 1);
            if (old > HALVE_LIMIT) begin
                for (int k = 0; k < 2; k++) begin
                    if (sec_model[held_sec_pair][k] > 1) begin
                        sec_model[held_sec_pair][k] = sec_model[held_sec_pair][k] >> 1;
                    end
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Rising edge: every handshake is observed here. Accepted inputs go through the
    // predictor in acceptance order, accepted results are checked against the oldest
    // prediction, and a configuration transaction updates the predictor's register.
    always @(posedge i_clk) begin : monitor
        t_coder_item seen;
        t_result     want;
        item_taken   = i_rst_n && item_bus.valid && item_bus.ready;
        result_taken = i_rst_n && result_bus.valid && result_bus.ready;
        cfg_taken    = i_rst_n && cfg_bus.valid && cfg_bus.ready;

        if (result_taken) begin
            if (freq_expected.size() == 0) begin
                report_mismatch($sformatf("result transaction with no prediction pending"));
            end else begin
                want = freq_expected.pop_front();
                if (result_bus.freq_zero !== want.freq_zero) begin
                    report_mismatch($sformatf("freq_zero got %0d, expected %0d",
                                              result_bus.freq_zero, want.freq_zero));
                end
                if (result_bus.freq_one !== want.freq_one) begin
                    report_mismatch($sformatf("freq_one got %0d, expected %0d",
                                              result_bus.freq_one, want.freq_one));
                end
                if (result_bus.freq_total !== want.freq_total) begin
                    report_mismatch($sformatf("freq_total got %0d, expected %0d",
                                              result_bus.freq_total, want.freq_total));
                end
                if (result_bus.from_secondary !== want.from_secondary) begin
                    report_mismatch($sformatf("from_secondary got %0b, expected %0b",
                                              result_bus.from_secondary,
                                              want.from_secondary));
                end
            end
        end

        if (item_taken) begin
            seen.cmd       = t_cmd'(item_bus.cmd);
            seen.ratio     = item_bus.ratio;
            seen.last_bits = item_bus.last_bits;
            seen.trend     = item_bus.trend;
            seen.depth     = item_bus.depth;
            seen.max_value = item_bus.max_value;
            seen.coded_bit = item_bus.coded_bit;
            if (seen.cmd == CMD_PREDICT) begin
                freq_expected.push_back(predict_frequencies(seen));
            end else begin
                train_pairs(seen.coded_bit);
            end
            accepted_items++;
        end

        if (cfg_taken) begin
            thresh_model = cfg_bus.data;
        end

        // The watchdog counts cycles in which no transaction of any kind completes.
        if (item_taken || result_taken || cfg_taken) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Falling edge: the sender. It offers items from the pending queue in bursts of random
    // length, with random gaps between bursts. An item stays on the bus until accepted,
    // and valid gets a single assignment per edge so back-to-back items never glitch.
    always @(negedge i_clk) begin : item_driver
        t_coder_item nxt;
        logic        next_valid;
        next_valid = item_bus.valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (item_taken) begin
                next_valid = 1'b0;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
                end
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    item_bus.cmd       <= nxt.cmd;
                    item_bus.ratio     <= nxt.ratio;
                    item_bus.last_bits <= nxt.last_bits;
                    item_bus.trend     <= nxt.trend;
                    item_bus.depth     <= nxt.depth;
                    item_bus.max_value <= nxt.max_value;
                    item_bus.coded_bit <= nxt.coded_bit;
                    next_valid = 1'b1;
                end
            end
        end
        item_bus.valid <= next_valid;
    end

    // Falling edge: the receiver. It switches between stall patterns, including stretches
    // with ready always high and stretches fully frozen. When the stimulus asks, it holds
    // off once for a long count of its own so the block fills and stalls its input.
    always @(negedge i_clk) begin : result_receiver
        logic rdy;
        if (hold_off_req && !hold_off_done) begin
            hold_left     = HOLD_OFF_LEN;
            hold_off_done = 1'b1;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 4));
            rx_mode_left = $urandom_range(16, 96);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_STEADY: rdy = 1'b1;
            RX_HALF:   rdy = 1'($urandom_range(0, 1));
            RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
            RX_EAGER:  rdy = ($urandom_range(0, 9) != 0);
            default:   rdy = 1'b0;
        endcase
        if (hold_left > 0) begin
            rdy = 1'b0;
            hold_left--;
        end
        result_bus.ready <= rdy;
    end

    function automatic t_coder_item context_of(input t_cmd cmd, input int ratio,
                                               input int last_bits, input int trend,
                                               input int depth, input int max_value,
                                               input int coded_bit);
        t_coder_item it;
        it.cmd       = cmd;
        it.ratio     = RATIO_W'(ratio);
        it.last_bits = LAST_BITS_W'(last_bits);
        it.trend     = TREND_W'(trend);
        it.depth     = DEPTH_W'(depth);
        it.max_value = MAXVAL_W'(max_value);
        it.coded_bit = coded_bit[0];
        return it;
    endfunction

    function automatic t_coder_item random_item();
        t_coder_item it;
        it.cmd       = $urandom_range(0, 1) ? CMD_UPDATE : CMD_PREDICT;
        it.ratio     = RATIO_W'($urandom);
        it.last_bits = LAST_BITS_W'($urandom);
        it.trend     = TREND_W'($urandom);
        it.depth     = DEPTH_W'($urandom);
        it.max_value = MAXVAL_W'($urandom);
        it.coded_bit = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic queue_item(input t_coder_item it);
        pending_items.push_back(it);
        queued_items++;
    endtask

    // Coding runs: a predict on a context from a small pool followed by a few updates whose
    // coded bit mostly follows that context's favored symbol, so entries grow to the
    // halving limit. About one run in ten is replaced by a stray random transaction.
    task automatic queue_coding_runs(input int runs, input int pool_n, input int min_upd,
                                     input int max_upd, input int bias_pct,
                                     input bit same_ratio);
        t_coder_item pool [8];
        logic        favored [8];
        t_coder_item it;
        int          k;
        int          n_upd;
        for (int p = 0; p < pool_n; p++) begin
            pool[p] = random_item();
            pool[p].cmd = CMD_PREDICT;
            if (same_ratio) begin
                pool[p].ratio = pool[0].ratio;
            end
            if ($urandom_range(0, 1)) begin
                pool[p].depth = DEPTH_W'($urandom_range(0, (1 << DEPTH_BITS) - 1));
            end
            if ($urandom_range(0, 1)) begin
                pool[p].max_value = MAXVAL_W'($urandom_range(0, MAXVAL_CLAMP));
            end
            favored[p] = same_ratio ? favored[0] : 1'($urandom_range(0, 1));
            if (p == 0) begin
                favored[0] = 1'($urandom_range(0, 1));
            end
        end
        repeat (runs) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_item(random_item());
            end else begin
                k = $urandom_range(0, pool_n - 1);
                it = pool[k];
                it.coded_bit = 1'($urandom_range(0, 1));
                queue_item(it);
                n_upd = $urandom_range(min_upd, max_upd);
                repeat (n_upd) begin
                    it = random_item();
                    it.cmd = CMD_UPDATE;
                    it.coded_bit = ($urandom_range(0, 99) < bias_pct) ? favored[k]
                                                                      : ~favored[k];
                    queue_item(it);
                end
            end
        end
    endtask

    // Waits until every queued item is accepted and every prediction has been answered,
    // then lets a trailing update finish its write back.
    task automatic wait_for_drain();
        do begin
            @(negedge i_clk);
        end while (accepted_items != queued_items || freq_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(input int value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= THRESH_W'(value);
        do begin
            @(negedge i_clk);
        end while (!cfg_taken);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin : stimulus
        wait (i_rst_n === 1'b1);

        // Directed part, under the reset threshold of 8.
        // Updates before any predict train pair zero of both tables; the first one's context
        // fields are all ones and must be ignored.
        queue_item(context_of(CMD_UPDATE, 15, 255, 3, 255, 255, 1));
        queue_item(context_of(CMD_UPDATE, 0, 0, 0, 0, 0, 0));
        // The all-zero context now totals 10: above the threshold and under the blend
        // limit, so the next max-value pair is added in.
        queue_item(context_of(CMD_PREDICT, 0, 0, 0, 0, 0, 1));
        // All fields at their top: depth saturates, max value clamps, and the fresh pair
        // is too small, so the secondary table answers.
        queue_item(context_of(CMD_PREDICT, 15, 255, 3, 255, 255, 0));
        queue_item(context_of(CMD_UPDATE, 0, 0, 0, 0, 0, 1));
        queue_item(context_of(CMD_UPDATE, 15, 255, 3, 255, 255, 0));
        // Same context again: the max value sits at the clamp, so there is no blend.
        queue_item(context_of(CMD_PREDICT, 15, 255, 3, 255, 255, 0));
        // Depth 7 and 8 land on the same saturated depth; history bits above the low
        // ones are dropped, so these two predicts read one pair.
        queue_item(context_of(CMD_PREDICT, 5, 8'hAA, 1, 7, 2, 0));
        queue_item(context_of(CMD_PREDICT, 5, 8'h02, 1, 8, 2, 0));
        queue_item(context_of(CMD_UPDATE, 0, 0, 0, 0, 0, 0));
        queue_item(context_of(CMD_UPDATE, 0, 0, 0, 0, 0, 0));
        // Max value 2 with a total of 10 blends with the clamped neighbor.
        queue_item(context_of(CMD_PREDICT, 5, 8'h02, 1, 200, 2, 1));
        // Max value 4 clamps to 3; then max value 1 is trained and blends with 2.
        queue_item(context_of(CMD_PREDICT, 9, 8'h01, 2, 3, 4, 0));
        queue_item(context_of(CMD_PREDICT, 9, 8'h01, 2, 3, 1, 0));
        queue_item(context_of(CMD_UPDATE, 0, 0, 0, 0, 0, 1));
        queue_item(context_of(CMD_UPDATE, 0, 0, 0, 0, 0, 1));
        queue_item(context_of(CMD_PREDICT, 9, 8'h01, 2, 3, 1, 0));
        queue_item(context_of(CMD_PREDICT, 9, 8'h01, 2, 3, 2, 1));
        wait_for_drain();

        // Threshold zero: the secondary table never answers nor learns. The receiver's
        // long hold-off falls at the start of this phase while the sender keeps going.
        write_threshold(0);
        queue_coding_runs(10, 3, 1, 3, 90, 1'b0);
        hold_off_req = 1'b1;
        wait_for_drain();

        // Threshold near its top: every primary total is below it, so every update also
        // trains the secondary pair. One ratio and one favored symbol drive that pair
        // past the halving limit, and the primary pairs halve several times on the way.
        write_threshold(THRESH_HIGH);
        queue_coding_runs(30, 2, 10, 12, 97, 1'b1);
        wait_for_drain();

        // A threshold near the blend limit mixes all three kinds of answers.
        write_threshold($urandom_range(9, 40));
        queue_coding_runs(6, 8, 1, 2, 70, 1'b0);
        wait_for_drain();

        // Random transactions under random thresholds, with broken sequences throughout.
        write_threshold($urandom_range(0, THRESH_HIGH));
        repeat (12) queue_item(random_item());
        wait_for_drain();
        write_threshold($urandom_range(1, THRESH_HIGH));
        queue_coding_runs(3, 4, 1, 3, 60, 1'b0);
        repeat (8) queue_item(random_item());
        wait_for_drain();

        repeat (2 * DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
